### hdl/cdct_pkg.sv
`timescale 1ns / 1ps
package cdct_pkg;
	localparam int HandlerW = 16;
	localparam int ParamW = 32;
	localparam int TickW = 32;
	localparam int SlackW = 16;
	localparam int LeftW = 5;
	localparam logic [SlackW-1:0] SlackReset = 16'd10;

	typedef enum logic [0:0] {OP_SCHED = 1'b0, OP_TICK = 1'b1} opcode_t;
	typedef enum logic [1:0] {KIND_ACK = 2'd0, KIND_FIRED = 2'd1, KIND_SUMMARY = 2'd2} kind_t;
	typedef enum logic [1:0] {ST_APPENDED = 2'd0, ST_RESTARTED = 2'd1, ST_DROPPED = 2'd2} status_t;
	typedef enum logic [1:0] {S_IDLE, S_SCHED, S_TICK} state_t;

	typedef struct packed {
		logic [HandlerW-1:0] handler;
		logic [ParamW-1:0]   param;
		logic [TickW-1:0]    start;
		logic [TickW-1:0]    delay;
	} entry_t;

	typedef struct packed {
		logic [0:0]          opcode;
		logic [TickW-1:0]    now_tick;
		logic [HandlerW-1:0] handler_id;
		logic [ParamW-1:0]   call_param;
		logic                match_param;
		logic [TickW-1:0]    delay_ticks;
	} req_t;

	typedef struct packed {
		logic [1:0]          result_kind;
		logic [1:0]          sched_status;
		logic [HandlerW-1:0] fired_handler;
		logic [ParamW-1:0]   fired_param;
		logic [TickW-1:0]    next_delay;
		logic                next_valid;
		logic [LeftW-1:0]    pending_left;
		logic                last_result;
	} rsp_t;

	typedef struct packed {
		logic   rotate;
		logic   load;
		entry_t load_entry;
	} cell_ctl_t;
endpackage

### hdl/cdct_if.sv
`timescale 1ns / 1ps
interface cdct_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/cdct_cell.sv
`timescale 1ns / 1ps
module cdct_cell (
	input  logic              clk,
	input  cdct_pkg::cell_ctl_t ctl,
	input  cdct_pkg::entry_t  prev_entry,
	output cdct_pkg::entry_t  entry
);
	import cdct_pkg::*;
	entry_t entry_q;
	always_ff @(posedge clk) begin
		if (ctl.load)
			entry_q <= ctl.load_entry;
		else if (ctl.rotate)
			entry_q <= prev_entry;
	end
	assign entry = entry_q;
endmodule

### hdl/coalescing_deferred_call_table.sv
`timescale 1ns / 1ps
// channel | dir | transaction
// cfg     | in  | fire_slack (16 bit)
// req     | in  | opcode, now_tick, handler_id, call_param, match_param, delay_ticks
// rsp     | out | result_kind, sched_status, fired_handler, fired_param,
//         |     | next_delay, next_valid, pending_left, last_result
// The table is a row of cells; the live entries form a ring whose head is cell 0.
// An item is accepted, then each live entry passes the head in turn, and a closing
// step issues the last result.
// A fired entry holds the scan while the result register is still full; the next
// transaction is taken only after the last result has left.
// Reset empties the table and restores fire_slack; cell contents are not cleared.
module coalescing_deferred_call_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	cdct_if.sink   cfg,
	cdct_if.sink   req,
	cdct_if.source rsp
);
	import cdct_pkg::*;
	localparam int IdxW = $clog2(TABLE_DEPTH + 1);

	entry_t    cell_out [TABLE_DEPTH];
	entry_t    cell_in [TABLE_DEPTH];
	cell_ctl_t cell_ctl [TABLE_DEPTH];

	state_t state_q, state_d;
	logic [SlackW-1:0] slack_q;
	req_t req_q;
	logic [IdxW-1:0] count_q, todo_q;
	logic found_q;
	logic have_q;
	logic [TickW-1:0] best_q;
	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q;

	entry_t head, new_entry;
	logic [TickW-1:0] el;
	logic [TickW:0] reach;
	logic [TickW-1:0] rem;
	logic busy, fire, hit, rsp_free, accept;
	logic step, step_drop, hit_load, app_load, rsp_load;
	logic [IdxW-1:0] last_idx, rot_len;

	assign head = cell_out[0];
	assign busy = todo_q != '0;
	assign accept = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign el = req_q.now_tick - head.start;
	assign reach = {1'b0, el} + {{(TickW+1-SlackW){1'b0}}, slack_q};
	assign fire = busy && (reach >= {1'b0, head.delay});
	assign rem = head.delay - el;
	assign hit = busy && !found_q && head.handler == req_q.handler_id
		&& (!req_q.match_param || head.param == req_q.call_param);
	assign last_idx = count_q - 1'b1;
	assign rot_len = step_drop ? last_idx : count_q;
	assign new_entry = '{handler: req_q.handler_id, param: req_q.call_param,
		start: req_q.now_tick, delay: req_q.delay_ticks};

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			if (g == TABLE_DEPTH - 1) begin : g_tail
				assign cell_in[g] = head;
			end else begin : g_mid
				assign cell_in[g] = (IdxW'(g) == last_idx) ? head : cell_out[g+1];
			end
			assign cell_ctl[g] = '{rotate: (step || step_drop) && (IdxW'(g) < rot_len),
				load: (hit_load && IdxW'(g) == last_idx)
					|| (app_load && IdxW'(g) == count_q),
				load_entry: new_entry};
			cdct_cell u_cell (.clk(clk), .ctl(cell_ctl[g]), .prev_entry(cell_in[g]),
				.entry(cell_out[g]));
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		step = 1'b0;
		step_drop = 1'b0;
		hit_load = 1'b0;
		app_load = 1'b0;
		rsp_load = 1'b0;
		rsp_d = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = (req.payload.opcode == OP_TICK) ? S_TICK : S_SCHED;
			end
			S_SCHED: begin
				if (busy) begin
					step = 1'b1;
					hit_load = hit;
				end else begin
					rsp_load = 1'b1;
					rsp_d.result_kind = KIND_ACK;
					rsp_d.last_result = 1'b1;
					rsp_d.pending_left = LeftW'(count_q);
					if (found_q) begin
						rsp_d.sched_status = ST_RESTARTED;
					end else if (count_q < IdxW'(TABLE_DEPTH)) begin
						app_load = 1'b1;
						rsp_d.sched_status = ST_APPENDED;
						rsp_d.pending_left = LeftW'(count_q + 1'b1);
					end else begin
						rsp_d.sched_status = ST_DROPPED;
					end
					state_d = S_IDLE;
				end
			end
			S_TICK: begin
				if (busy) begin
					if (!fire) begin
						step = 1'b1;
					end else if (rsp_free) begin
						step_drop = 1'b1;
						rsp_load = 1'b1;
						rsp_d.result_kind = KIND_FIRED;
						rsp_d.fired_handler = head.handler;
						rsp_d.fired_param = head.param;
						rsp_d.pending_left = LeftW'(count_q - 1'b1);
					end
				end else if (rsp_free) begin
					rsp_load = 1'b1;
					rsp_d.result_kind = KIND_SUMMARY;
					rsp_d.next_delay = have_q ? best_q : '0;
					rsp_d.next_valid = count_q != '0;
					rsp_d.pending_left = LeftW'(count_q);
					rsp_d.last_result = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slack_q <= SlackReset;
			req_q <= '0;
			count_q <= '0;
			todo_q <= '0;
			found_q <= 1'b0;
			have_q <= 1'b0;
			best_q <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready)
				slack_q <= cfg.payload;
			if (accept) begin
				req_q <= req.payload;
				todo_q <= count_q;
				found_q <= 1'b0;
				have_q <= 1'b0;
				best_q <= '0;
			end else begin
				if (step || step_drop)
					todo_q <= todo_q - 1'b1;
				if (hit_load)
					found_q <= 1'b1;
				if (step && state_q == S_TICK) begin
					have_q <= 1'b1;
					if (!have_q || rem < best_q)
						best_q <= rem;
				end
			end
			if (step_drop)
				count_q <= count_q - 1'b1;
			else if (app_load)
				count_q <= count_q + 1'b1;
			if (rsp_load)
				rsp_q <= rsp_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign cfg.ready = 1'b1;
	assign req.ready = state_q == S_IDLE && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;
endmodule
